/* src/u8d_pkg.sv */
// Shared types, constants and helper functions for the UTF-8 decoder with Latin-1 fallback.
package u8d_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned LenW   = 3;
  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = 3;  // holds 0 to MaxRes
  localparam int unsigned IdxW   = 2;

  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContCode  = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Code = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Code = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Code = 8'hF0;

  localparam logic [LenW-1:0] LenNone = 3'd0;
  localparam logic [LenW-1:0] LenOne  = 3'd1;
  localparam logic [LenW-1:0] LenTwo  = 3'd2;
  localparam logic [LenW-1:0] LenThr  = 3'd3;
  localparam logic [LenW-1:0] LenFour = 3'd4;

  localparam logic [CpW-1:0] Min2 = 21'h00080;
  localparam logic [CpW-1:0] Min3 = 21'h00800;
  localparam logic [CpW-1:0] Min4 = 21'h10000;

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
  } u8d_ent_t;

  typedef struct packed {
    u8d_ent_t [MaxRes-1:0] ents;
    logic [CntW-1:0]       cnt;
    logic                  eot;
  } u8d_burst_t;

  function automatic logic [LenW-1:0] lead_len(input logic [7:0] b);
    logic [LenW-1:0] l;
    if ((b & Lead2Mask) == Lead2Code)      l = LenTwo;
    else if ((b & Lead3Mask) == Lead3Code) l = LenThr;
    else if ((b & Lead4Mask) == Lead4Code) l = LenFour;
    else                                   l = LenNone;
    return l;
  endfunction

  function automatic logic is_break(input logic [CpW-1:0] cp);
    return cp == 21'h2E || cp == 21'h2C || cp == 21'h21 || cp == 21'h3F ||
           cp == 21'h3B || cp == 21'h3A || cp == 21'h2D;
  endfunction

  function automatic u8d_ent_t latin1(input logic [7:0] b);
    u8d_ent_t e;
    e.cp  = {13'd0, b};
    e.len = LenOne;
    return e;
  endfunction

endpackage

/* src/u8d_if.sv */
// Byte input and code point result channel interfaces.
interface u8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_text;

  modport source (output valid, output byte_in, output end_of_text, input ready);
  modport sink   (input valid, input byte_in, input end_of_text, output ready);
endinterface

interface u8d_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  byte_length;
  logic        break_after;
  logic        run_last;
  logic        text_done;

  modport source (output valid, output code_point, output byte_length, output break_after,
                  output run_last, output text_done, input ready);
  modport sink   (input valid, input code_point, input byte_length, input break_after,
                  input run_last, input text_done, output ready);
endinterface

/* src/utf8_decoder_latin1_fallback_unit.sv */
// Top level of the UTF-8 decoder with Latin-1 fallback.
//
//   channel  dir  handshake           payload
//   in_ch    in   valid/ready         byte_in[7:0], end_of_text
//   out_ch   out  valid/ready         code_point[20:0], byte_length[2:0],
//                                     break_after, run_last, text_done
//
// One byte enters per cycle unless the output stalls; it is decoded in the cycle
// after its transfer, and its results then leave the result register one per cycle.
// A byte giving several results (at most 4) holds the input until its last is taken,
// so bytes that only buffer or give one result sustain one byte per cycle.
// Synchronous active-low reset empties both registers and drops any open sequence.
// A stalled output holds the current result and back-pressures the input.
module utf8_decoder_latin1_fallback_unit
  import u8d_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  u8d_in_if.sink    in_ch,
  u8d_out_if.source out_ch
);

  logic       burst_valid;
  logic       burst_ready;
  u8d_burst_t burst;

  u8d_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_byte     (in_ch.byte_in),
    .in_eot      (in_ch.end_of_text),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst)
  );

  u8d_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .burst_valid (burst_valid),
    .burst_ready (burst_ready),
    .burst       (burst),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_cp      (out_ch.code_point),
    .out_len     (out_ch.byte_length),
    .out_brk     (out_ch.break_after),
    .out_last    (out_ch.run_last),
    .out_done    (out_ch.text_done)
  );

endmodule

/* src/u8d_seq.sv */
// Input register, sequence state and single-pass decode of one byte into a result burst.
module u8d_seq
  import u8d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_eot,
  output logic       burst_valid,
  input  logic       burst_ready,
  output u8d_burst_t burst
);

  logic            hold_r;
  logic [7:0]      byte_r;
  logic            eot_r;
  logic [7:0]      pend_r [3];
  logic [7:0]      pend_nxt [3];
  logic [1:0]      pcnt_r, pcnt_nxt;
  logic [LenW-1:0] slen_r, slen_nxt;

  logic            advance;
  logic            is_cont;
  logic            fresh;
  logic [LenW-1:0] blen;
  logic [CpW-1:0]  cp;
  logic [CpW-1:0]  cp_min;
  u8d_ent_t [MaxRes-1:0] ents;
  logic [CntW-1:0] n;

  assign is_cont = (byte_r & ContMask) == ContCode;
  assign blen    = lead_len(byte_r);

  // Assemble the complete sequence from the buffered bytes and the closing byte
  always_comb begin
    case (slen_r)
      LenTwo:  begin
        cp     = {10'd0, pend_r[0][4:0], byte_r[5:0]};
        cp_min = Min2;
      end
      LenThr:  begin
        cp     = {5'd0, pend_r[0][3:0], pend_r[1][5:0], byte_r[5:0]};
        cp_min = Min3;
      end
      default: begin
        cp     = {pend_r[0][2:0], pend_r[1][5:0], pend_r[2][5:0], byte_r[5:0]};
        cp_min = Min4;
      end
    endcase
  end

  always_comb begin
    n        = '0;
    ents     = '0;
    pend_nxt = pend_r;
    pcnt_nxt = pcnt_r;
    slen_nxt = slen_r;
    fresh    = 1'b1;
    if (slen_r != LenNone) begin
      if (is_cont) begin
        fresh = 1'b0;
        if (({1'b0, pcnt_r} + 3'd1) >= slen_r || pcnt_r == 2'd3) begin
          pcnt_nxt = '0;
          slen_nxt = LenNone;
          if (cp >= cp_min) begin
            ents[0].cp  = cp;
            ents[0].len = slen_r;
            n           = 3'd1;
          end else begin
            for (int i = 0; i < 3; i++) begin
              if (i < int'(pcnt_r)) begin
                ents[n[IdxW-1:0]] = latin1(pend_r[i]);
                n                 = n + 3'd1;
              end
            end
            ents[n[IdxW-1:0]] = latin1(byte_r);
            n                 = n + 3'd1;
          end
        end else begin
          pend_nxt[pcnt_r] = byte_r;
          pcnt_nxt         = pcnt_r + 2'd1;
          if (eot_r) begin
            // cut off by the end of the string: flush everything as Latin-1
            for (int i = 0; i < 3; i++) begin
              if (i < int'(pcnt_r)) begin
                ents[n[IdxW-1:0]] = latin1(pend_r[i]);
                n                 = n + 3'd1;
              end
            end
            ents[n[IdxW-1:0]] = latin1(byte_r);
            n                 = n + 3'd1;
            pcnt_nxt          = '0;
            slen_nxt          = LenNone;
          end
        end
      end else begin
        // broken sequence: flush, then treat the byte afresh
        for (int i = 0; i < 3; i++) begin
          if (i < int'(pcnt_r)) begin
            ents[n[IdxW-1:0]] = latin1(pend_r[i]);
            n                 = n + 3'd1;
          end
        end
        pcnt_nxt = '0;
        slen_nxt = LenNone;
      end
    end
    if (fresh) begin
      if (byte_r[7] == 1'b0 || blen == LenNone) begin
        ents[n[IdxW-1:0]] = latin1(byte_r);
        n                 = n + 3'd1;
      end else if (eot_r) begin
        ents[n[IdxW-1:0]] = latin1(byte_r);
        n                 = n + 3'd1;
        pcnt_nxt          = '0;
        slen_nxt          = LenNone;
      end else begin
        pend_nxt[0] = byte_r;
        pcnt_nxt    = 2'd1;
        slen_nxt    = blen;
      end
    end
  end

  assign burst_valid = hold_r && (n != '0);
  assign advance     = hold_r && ((n == '0) || burst_ready);
  assign in_ready    = !hold_r || advance;

  assign burst.ents = ents;
  assign burst.cnt  = n;
  assign burst.eot  = eot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      pcnt_r <= '0;
      slen_r <= LenNone;
    end else begin
      if (in_ready) begin
        hold_r <= in_valid;
      end
      if (advance) begin
        pcnt_r <= pcnt_nxt;
        slen_r <= slen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_byte;
      eot_r  <= in_eot;
    end
    if (advance) begin
      pend_r <= pend_nxt;
    end
  end

endmodule

/* src/u8d_emit.sv */
// Result register that hands out one code point of a burst per transfer.
module u8d_emit
  import u8d_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             burst_valid,
  output logic             burst_ready,
  input  u8d_burst_t       burst,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [CpW-1:0]   out_cp,
  output logic [LenW-1:0]  out_len,
  output logic             out_brk,
  output logic             out_last,
  output logic             out_done
);

  logic                  busy_r;
  u8d_ent_t [MaxRes-1:0] ents_r;
  logic [CntW-1:0]       cnt_r;
  logic [IdxW-1:0]       idx_r;
  logic                  eot_r;
  logic                  last;

  assign last        = ({1'b0, idx_r} + 3'd1) == cnt_r;
  assign burst_ready = !busy_r || (last && out_ready);

  assign out_valid = busy_r;
  assign out_cp    = ents_r[idx_r].cp;
  assign out_len   = ents_r[idx_r].len;
  assign out_brk   = is_break(ents_r[idx_r].cp);
  assign out_last  = last;
  assign out_done  = last && eot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (burst_ready) begin
      busy_r <= burst_valid;
      idx_r  <= '0;
    end else if (out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (burst_ready && burst_valid) begin
      ents_r <= burst.ents;
      cnt_r  <= burst.cnt;
      eot_r  <= burst.eot;
    end
  end

endmodule

/* test/utf8_decoder_latin1_fallback_unit_test.sv */
// Self-checking testbench for the UTF-8 decoder with Latin-1 fallback.
module utf8_decoder_latin1_fallback_unit_test
  import u8d_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic       drain_first;
  } text_byte_t;

  typedef struct packed {
    logic [CpW-1:0]  cp;
    logic [LenW-1:0] len;
    logic            brk;
    logic            run_last;
    logic            text_done;
  } code_point_t;

  localparam int unsigned RandomBytes  = 140;
  localparam int unsigned ReceiverHold = 64;
  localparam logic [7:0] Punct [7] = '{8'h2E, 8'h2C, 8'h21, 8'h3F, 8'h3B, 8'h3A, 8'h2D};

  logic clk;
  logic rst_n;

  u8d_in_if  in_ch ();
  u8d_out_if out_ch ();

  utf8_decoder_latin1_fallback_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  text_byte_t  text_bytes_q [$];
  code_point_t expected_cps_q [$];
  code_point_t step_cps_q [$];

  // decoder state mirror
  logic [7:0]      held_bytes [3];
  int unsigned     held_count = 0;
  logic [LenW-1:0] open_len = LenNone;

  int unsigned bytes_in = 0;
  int unsigned cps_out = 0;
  int unsigned text_total = 0;
  int unsigned errors = 0;
  logic        in_xfer = 1'b0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  text_byte_t  next_byte;
  code_point_t want;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned sender_idle();
    if (bytes_in < text_total / 3) return 23;
    if (bytes_in < 2 * text_total / 3) return 60;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle();
    if (bytes_in < text_total / 3) return 60;
    if (bytes_in < 2 * text_total / 3) return 23;
    return 0;
  endfunction

  function automatic code_point_t make_cp(logic [CpW-1:0] cp, logic [LenW-1:0] len);
    code_point_t r;
    r.cp        = cp;
    r.len       = len;
    r.brk       = 1'b0;
    r.run_last  = 1'b0;
    r.text_done = 1'b0;
    foreach (Punct[i]) if (cp == {13'd0, Punct[i]}) r.brk = 1'b1;
    return r;
  endfunction

  task automatic flush_held();
    for (int i = 0; i < held_count; i++) step_cps_q.push_back(make_cp({13'd0, held_bytes[i]}, LenOne));
    held_count = 0;
    open_len   = LenNone;
  endtask

  task automatic decode_byte(logic [7:0] b, logic eot);
    logic [CpW-1:0]  acc;
    logic [CpW-1:0]  floor_cp;
    logic [LenW-1:0] lead;
    logic            taken;
    code_point_t     last;
    step_cps_q.delete();
    taken = 1'b0;
    if (open_len != LenNone) begin
      if ((b & ContMask) == ContCode) begin
        taken = 1'b1;
        if (held_count + 1 >= open_len) begin
          case (open_len)
            LenTwo: begin
              acc      = {16'd0, held_bytes[0][4:0]};
              floor_cp = Min2;
            end
            LenThr: begin
              acc      = {17'd0, held_bytes[0][3:0]};
              floor_cp = Min3;
            end
            default: begin
              acc      = {18'd0, held_bytes[0][2:0]};
              floor_cp = Min4;
            end
          endcase
          for (int i = 1; i < held_count; i++) acc = {acc[CpW-7:0], held_bytes[i][5:0]};
          acc = {acc[CpW-7:0], b[5:0]};
          if (acc >= floor_cp) begin
            step_cps_q.push_back(make_cp(acc, open_len));
            held_count = 0;
            open_len   = LenNone;
          end else begin
            // overlong: everything goes out byte by byte
            flush_held();
            step_cps_q.push_back(make_cp({13'd0, b}, LenOne));
          end
        end else begin
          held_bytes[held_count] = b;
          held_count++;
          if (eot) flush_held();
        end
      end else begin
        // broken sequence: flush, then treat the byte afresh
        flush_held();
      end
    end
    if (!taken) begin
      if (b[7] == 1'b0) begin
        step_cps_q.push_back(make_cp({13'd0, b}, LenOne));
      end else begin
        if ((b & Lead2Mask) == Lead2Code)      lead = LenTwo;
        else if ((b & Lead3Mask) == Lead3Code) lead = LenThr;
        else if ((b & Lead4Mask) == Lead4Code) lead = LenFour;
        else                                   lead = LenNone;
        if (lead != LenNone) begin
          held_bytes[0] = b;
          held_count    = 1;
          open_len      = lead;
          if (eot) flush_held();
        end else begin
          step_cps_q.push_back(make_cp({13'd0, b}, LenOne));
        end
      end
    end
    if (step_cps_q.size() != 0) begin
      last           = step_cps_q.pop_back();
      last.run_last  = 1'b1;
      last.text_done = eot;
      step_cps_q.push_back(last);
    end
    foreach (step_cps_q[i]) expected_cps_q.push_back(step_cps_q[i]);
  endtask

  task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
    errors++;
  endtask

  task automatic push_byte(logic [7:0] b, logic eot);
    text_byte_t t;
    t.data        = b;
    t.eot         = eot;
    t.drain_first = 1'b0;
    text_bytes_q.push_back(t);
  endtask

  // push n bytes, most significant first; eot marks the last one
  task automatic push_seq(int unsigned n, logic [31:0] bytes, logic eot);
    for (int k = n - 1; k >= 0; k--) push_byte(bytes[8*k +: 8], eot && k == 0);
  endtask

  task automatic push_encoded(int unsigned cp, int unsigned n);
    logic [7:0] prefix;
    if (n == 1) begin
      push_byte(cp[7:0], 1'b0);
    end else begin
      prefix = (n == 2) ? 8'hC0 : (n == 3) ? 8'hE0 : 8'hF0;
      push_byte(prefix | 8'(cp >> (6 * (n - 1))), 1'b0);
      for (int k = n - 2; k >= 0; k--) push_byte(8'h80 | (8'(cp >> (6 * k)) & 8'h3F), 1'b0);
    end
  endtask

  task automatic mark_text_end();
    text_byte_t t;
    t     = text_bytes_q.pop_back();
    t.eot = 1'b1;
    text_bytes_q.push_back(t);
  endtask

  // byte driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_xfer) begin
      if (text_bytes_q.size() != 0 &&
          (!text_bytes_q[0].drain_first || expected_cps_q.size() == 0) &&
          $urandom_range(0, 99) >= sender_idle()) begin
        next_byte = text_bytes_q.pop_front();
        in_ch.valid       <= 1'b1;
        in_ch.byte_in     <= next_byte.data;
        in_ch.end_of_text <= next_byte.eot;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && cps_out >= 30) begin
      hold_left    <= ReceiverHold;
      hold_done    <= 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= receiver_idle());
    end
  end

  // monitor: check results, then predict from accepted bytes
  always @(posedge clk) begin
    if (!rst_n) begin
      in_xfer <= 1'b0;
    end else begin
      in_xfer <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        cps_out++;
        if (expected_cps_q.size() == 0) begin
          report_mismatch("unexpected code point", out_ch.code_point, 0);
        end else begin
          want = expected_cps_q.pop_front();
          if (out_ch.code_point !== want.cp)
            report_mismatch("code_point", out_ch.code_point, want.cp);
          if (out_ch.byte_length !== want.len)
            report_mismatch("byte_length", out_ch.byte_length, want.len);
          if (out_ch.break_after !== want.brk)
            report_mismatch("break_after", out_ch.break_after, want.brk);
          if (out_ch.run_last !== want.run_last)
            report_mismatch("run_last", out_ch.run_last, want.run_last);
          if (out_ch.text_done !== want.text_done)
            report_mismatch("text_done", out_ch.text_done, want.text_done);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.byte_in, in_ch.end_of_text);
        bytes_in++;
      end
    end
  end

  initial begin
    int unsigned directed_n;
    int unsigned chars_left;
    int unsigned pick;
    int unsigned n;
    int unsigned cp;
    text_byte_t  t;
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.byte_in     = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready      = 1'b0;

    push_seq(1, 32'h00, 1'b0);
    push_seq(1, 32'h7F, 1'b0);
    push_seq(1, 32'h2D, 1'b0);
    push_seq(2, 32'hC3A9, 1'b0);
    push_seq(2, 32'hC1BF, 1'b0);          // overlong pair
    push_seq(3, 32'hE282AC, 1'b0);
    push_seq(3, 32'hE09FBF, 1'b0);        // overlong triple
    push_seq(4, 32'hF7BFBFBF, 1'b0);      // top of the code point range
    push_seq(4, 32'hF08FBFBF, 1'b0);      // overlong quad
    push_seq(4, 32'hF0908041, 1'b0);      // broken after three bytes held
    push_seq(1, 32'h80, 1'b0);            // stray continuation
    push_seq(1, 32'hFF, 1'b0);            // never a lead
    push_seq(2, 32'hE282, 1'b1);          // cut off by end of text
    push_seq(1, 32'hF0, 1'b1);            // lone lead at end of text
    directed_n = text_bytes_q.size();

    chars_left = $urandom_range(1, 10);
    while (text_bytes_q.size() < directed_n + RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        n = $urandom_range(1, 4);
        case (n)
          1: cp = ($urandom_range(0, 3) == 0) ? Punct[$urandom_range(0, 6)] :
                  $urandom_range(0, 127);
          2: cp = $urandom_range(128, 2047);
          3: cp = $urandom_range(2048, 65535);
          default: cp = $urandom_range(65536, 2097151);
        endcase
        push_encoded(cp, n);
      end else if (pick < 78) begin
        n  = $urandom_range(2, 4);
        cp = $urandom_range(0, (n == 2) ? 127 : (n == 3) ? 2047 : 65535);
        push_encoded(cp, n);
      end else if (pick < 88) begin
        // truncated sequence, sometimes cut off by end of text
        n = $urandom_range(2, 4);
        case (n)
          2: push_byte(8'hC0 | 8'($urandom_range(0, 31)), 1'b0);
          3: push_byte(8'hE0 | 8'($urandom_range(0, 15)), 1'b0);
          default: push_byte(8'hF0 | 8'($urandom_range(0, 7)), 1'b0);
        endcase
        repeat ($urandom_range(0, n - 2)) push_byte(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
        if ($urandom_range(0, 2) == 0) mark_text_end();
      end else begin
        push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      chars_left--;
      if (chars_left == 0) begin
        mark_text_end();
        chars_left = $urandom_range(1, 10);
      end
    end
    mark_text_end();

    // hold the sender here until every result so far has arrived
    t = text_bytes_q[directed_n + RandomBytes / 2];
    t.drain_first = 1'b1;
    text_bytes_q[directed_n + RandomBytes / 2] = t;
    text_total = text_bytes_q.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (bytes_in != text_total || expected_cps_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
